FILE: rtl/sdf2d_pkg.sv
// ----------------------------------------------------------------------------
// sdf2d_pkg
// shared types and constants of the 2d distance field evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdf2d_pkg;

  // fixed item field widths
  localparam int PT_W   = 16;
  localparam int DIST_W = 18;
  localparam int RAD_W  = 15;
  localparam int SHP_W  = 2;

  // default fraction bits of the fixed point formats
  localparam int FRAC_BITS_DEF = 12;

  // 1/sqrt(2) in q0.16
  localparam int INV_SQRT2_Q16 = 46341;

  // output clamp bounds
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic REG_SHAPE  = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  localparam logic [SHP_W-1:0] SHAPE_RST  = 2'd2;
  localparam logic [RAD_W-1:0] RADIUS_RST = 15'd4096;

  typedef enum logic [SHP_W-1:0] {
    SHAPE_CIRCLE   = 2'd0,
    SHAPE_BOX      = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SEGMENT  = 2'd3
  } shape_t;

endpackage

`default_nettype wire

FILE: rtl/sdf2d_if.sv
// ----------------------------------------------------------------------------
// sdf2d_if
// valid/ready channels for query points and distance results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sdf2d_pt_if
  import sdf2d_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface sdf2d_dist_if
  import sdf2d_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

`default_nettype wire

FILE: rtl/sdf2d_front.sv
// ----------------------------------------------------------------------------
// sdf2d_front
// region decode, squares and diagonal product ahead of the root chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdf2d_front
  import sdf2d_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CW        = 17,
  parameter int XW        = 18
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire logic signed [PT_W-1:0] point_x,
  input  wire logic signed [PT_W-1:0] point_y,
  input  wire shape_t                 shape,
  input  wire logic [RAD_W-1:0]       radius,
  output logic                        o_vld,
  output logic [2*CW+1:0]             o_rad,
  output logic signed [XW-1:0]        o_off
);

  typedef enum logic [1:0] {
    OFF_LIN      = 2'd0,
    OFF_DIAG     = 2'd1,
    OFF_DIAG_MAX = 2'd2
  } off_kind_t;

  localparam logic signed [XW-1:0] ONE_FX = XW'(64'd1 << FRAC_BITS);
  localparam logic signed [17:0]   INV_C  = 18'(INV_SQRT2_Q16);
  localparam int PW = XW + 18;

  // stage 1 decode
  logic signed [XW-1:0] xs, ys, ax, ay, d1x, d2y, s, bdx, bdy, bmax;
  logic [CW-1:0]        s1_vx_nxt, s1_vy_nxt;
  logic signed [XW-1:0] s1_off_nxt, s1_m1_nxt;
  off_kind_t            s1_kind_nxt;

  logic                 s1_vld_r;
  logic [CW-1:0]        s1_vx_r, s1_vy_r;
  logic signed [XW-1:0] s1_s_r, s1_m1_r, s1_off_r;
  off_kind_t            s1_kind_r;

  logic                 s2_vld_r;
  logic [2*CW-1:0]      s2_sqx_r, s2_sqy_r;
  logic signed [PW-1:0] s2_prod_r;
  logic signed [XW-1:0] s2_m1_r, s2_off_r;
  off_kind_t            s2_kind_r;

  logic signed [PW:0]   prod_rnd;
  logic signed [XW-1:0] diag, o_off_nxt;
  logic [2*CW+1:0]      o_rad_nxt;
  logic                 o_vld_r;
  logic [2*CW+1:0]      o_rad_r;
  logic signed [XW-1:0] o_off_r;

  always_comb begin
    xs   = {{(XW-PT_W){point_x[PT_W-1]}}, point_x};
    ys   = {{(XW-PT_W){point_y[PT_W-1]}}, point_y};
    ax   = (xs < 0) ? -xs : xs;
    ay   = (ys < 0) ? -ys : ys;
    d1x  = xs - ONE_FX;
    d2y  = ys - ONE_FX;
    s    = xs + ys - ONE_FX;
    bdx  = ax - ONE_FX;
    bdy  = ay - ONE_FX;
    bmax = (bdx > bdy) ? bdx : bdy;

    s1_vx_nxt   = '0;
    s1_vy_nxt   = '0;
    s1_off_nxt  = '0;
    s1_m1_nxt   = (-xs > -ys) ? -xs : -ys;
    s1_kind_nxt = OFF_LIN;

    case (shape)
      SHAPE_CIRCLE: begin
        s1_vx_nxt  = ax[CW-1:0];
        s1_vy_nxt  = ay[CW-1:0];
        s1_off_nxt = -$signed({{(XW-RAD_W){1'b0}}, radius});
      end
      SHAPE_BOX: begin
        s1_vx_nxt  = (bdx > 0) ? bdx[CW-1:0] : '0;
        s1_vy_nxt  = (bdy > 0) ? bdy[CW-1:0] : '0;
        s1_off_nxt = (bmax < 0) ? bmax : '0;
      end
      SHAPE_TRIANGLE: begin
        if (xs < 0 && ys < 0) begin
          s1_vx_nxt = ax[CW-1:0];
          s1_vy_nxt = ay[CW-1:0];
        end else if (d1x > 0 && ys <= d1x) begin
          // corner (1,0)
          s1_vx_nxt = d1x[CW-1:0];
          s1_vy_nxt = ay[CW-1:0];
        end else if (d2y > 0 && d2y >= xs) begin
          // corner (0,1)
          s1_vx_nxt = ax[CW-1:0];
          s1_vy_nxt = d2y[CW-1:0];
        end else if (ys < 0) begin
          s1_off_nxt = -ys;
        end else if (xs < 0) begin
          s1_off_nxt = -xs;
        end else if (s > 0) begin
          s1_kind_nxt = OFF_DIAG;
        end else begin
          s1_kind_nxt = OFF_DIAG_MAX;
        end
      end
      default: begin
        if (xs >= 0 && xs <= ONE_FX) begin
          s1_off_nxt = ys;
        end else if (xs < 0) begin
          s1_vx_nxt = ax[CW-1:0];
          s1_vy_nxt = ay[CW-1:0];
        end else begin
          s1_vx_nxt = d1x[CW-1:0];
          s1_vy_nxt = ay[CW-1:0];
        end
      end
    endcase
  end

  // stage 3: sum of squares, rounded diagonal distance
  always_comb begin
    prod_rnd  = {s2_prod_r[PW-1], s2_prod_r} + (PW+1)'(32768);
    diag      = XW'(prod_rnd >>> 16);
    o_rad_nxt = {2'b00, s2_sqx_r} + {2'b00, s2_sqy_r};
    case (s2_kind_r)
      OFF_DIAG:     o_off_nxt = diag;
      OFF_DIAG_MAX: o_off_nxt = (s2_m1_r > diag) ? s2_m1_r : diag;
      default:      o_off_nxt = s2_off_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      o_vld_r  <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vx_r   <= s1_vx_nxt;
      s1_vy_r   <= s1_vy_nxt;
      s1_s_r    <= s;
      s1_m1_r   <= s1_m1_nxt;
      s1_off_r  <= s1_off_nxt;
      s1_kind_r <= s1_kind_nxt;

      s2_sqx_r  <= s1_vx_r * s1_vx_r;
      s2_sqy_r  <= s1_vy_r * s1_vy_r;
      s2_prod_r <= PW'(s1_s_r * INV_C);
      s2_m1_r   <= s1_m1_r;
      s2_off_r  <= s1_off_r;
      s2_kind_r <= s1_kind_r;

      o_rad_r   <= o_rad_nxt;
      o_off_r   <= o_off_nxt;
    end
  end

  assign o_vld = o_vld_r;
  assign o_rad = o_rad_r;
  assign o_off = o_off_r;

endmodule

`default_nettype wire

FILE: rtl/sdf2d_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sdf2d_sqrt_cell
// one digit step of the integer square root, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdf2d_sqrt_cell
  import sdf2d_pkg::*;
#(
  parameter int RW = 18,
  parameter int XW = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 i_vld,
  input  wire logic [2*RW-1:0]      i_rad,
  input  wire logic [RW+1:0]        i_rem,
  input  wire logic [RW-1:0]        i_root,
  input  wire logic signed [XW-1:0] i_off,
  output logic                      o_vld,
  output logic [2*RW-1:0]           o_rad,
  output logic [RW+1:0]             o_rem,
  output logic [RW-1:0]             o_root,
  output logic signed [XW-1:0]      o_off
);

  logic [RW+1:0]        shifted, trial, rem_nxt;
  logic                 ge;
  logic                 vld_r;
  logic [2*RW-1:0]      rad_r;
  logic [RW+1:0]        rem_r;
  logic [RW-1:0]        root_r;
  logic signed [XW-1:0] off_r;

  // remainder stays below 2^RW while digits remain, root below 2^(RW-1)
  always_comb begin
    shifted = {i_rem[RW-1:0], i_rad[2*RW-1 -: 2]};
    trial   = {1'b0, i_root[RW-2:0], 2'b01};
    ge      = (shifted >= trial);
    rem_nxt = ge ? (shifted - trial) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {i_rad[2*RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {i_root[RW-2:0], ge};
      off_r  <= i_off;
    end
  end

  assign o_vld  = vld_r;
  assign o_rad  = rad_r;
  assign o_rem  = rem_r;
  assign o_root = root_r;
  assign o_off  = off_r;

endmodule

`default_nettype wire

FILE: rtl/sdf2d_primitive_eval.sv
// ----------------------------------------------------------------------------
// sdf2d_primitive_eval
// signed distance from a 2d point to a circle, box, triangle or segment
// ----------------------------------------------------------------------------
// Takes one query point per cycle and returns one signed distance item per
// point, in input order. Each item passes three front stages for region
// decode, squaring and the diagonal product, then a chain of RW square root
// cells, with RW = max(FRAC_BITS, 15) + 3, that each resolve one bit of the
// length, then the output register that adds the offset and clamps. One item
// is accepted every cycle as long as the result side takes items; a stall on
// the result side holds the whole pipeline. The shape and radius registers
// are sampled as an item enters, so write them only while no item is in
// flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdf2d_primitive_eval
  import sdf2d_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sdf2d_pt_if.sink               in_pt,
  sdf2d_dist_if.source           out_dist,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  // vector component magnitude width, signed working width, root width
  localparam int MW = (FRAC_BITS > 15) ? FRAC_BITS : 15;
  localparam int CW = MW + 2;
  localparam int XW = CW + 1;
  localparam int RW = CW + 1;
  localparam int SW = XW + 2;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic             cfg_wr;
  shape_t           shape_r;
  logic [RAD_W-1:0] radius_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= shape_t'(SHAPE_RST);
      radius_r <= RADIUS_RST;
    end else if (cfg_wr) begin
      // word decode, low address bits ignored
      if (cfg_paddr[2] == REG_SHAPE) begin
        shape_r <= shape_t'(cfg_pwdata[SHP_W-1:0]);
      end else begin
        radius_r <= cfg_pwdata[RAD_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_RADIUS) begin
      cfg_prdata = {{(CFG_DW-RAD_W){1'b0}}, radius_r};
    end else begin
      cfg_prdata = {{(CFG_DW-SHP_W){1'b0}}, shape_r};
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: everything moves unless a finished item is stuck
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_vld_r;
  logic signed [DIST_W-1:0] out_dist_r;

  assign adv         = !out_vld_r || out_dist.ready;
  assign in_pt.ready = adv;

  // ---------------------------------------------------------------------------
  // front stages: region decode, radicand and additive offset
  // ---------------------------------------------------------------------------
  logic                 ch_vld  [0:RW];
  logic [2*RW-1:0]      ch_rad  [0:RW];
  logic [RW+1:0]        ch_rem  [0:RW];
  logic [RW-1:0]        ch_root [0:RW];
  logic signed [XW-1:0] ch_off  [0:RW];

  sdf2d_front #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW),
    .XW        (XW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_pt.valid),
    .point_x (in_pt.point_x),
    .point_y (in_pt.point_y),
    .shape   (shape_r),
    .radius  (radius_r),
    .o_vld   (ch_vld[0]),
    .o_rad   (ch_rad[0]),
    .o_off   (ch_off[0])
  );

  // the root chain starts with zero remainder and zero root
  assign ch_rem[0]  = '0;
  assign ch_root[0] = '0;

  // ---------------------------------------------------------------------------
  // root chain, one result bit per cell, most significant first
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < RW; gi++) begin : g_cell
    sdf2d_sqrt_cell #(
      .RW (RW),
      .XW (XW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .i_vld  (ch_vld[gi]),
      .i_rad  (ch_rad[gi]),
      .i_rem  (ch_rem[gi]),
      .i_root (ch_root[gi]),
      .i_off  (ch_off[gi]),
      .o_vld  (ch_vld[gi+1]),
      .o_rad  (ch_rad[gi+1]),
      .o_rem  (ch_rem[gi+1]),
      .o_root (ch_root[gi+1]),
      .o_off  (ch_off[gi+1])
    );
  end

  // ---------------------------------------------------------------------------
  // length plus offset, clamp to the output range
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]     sum;
  logic signed [DIST_W-1:0] dist_nxt;

  always_comb begin
    sum = $signed({2'b00, ch_root[RW]}) + {{2{ch_off[RW][XW-1]}}, ch_off[RW]};
    if (sum > SW'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else if (sum < SW'(DIST_MIN)) begin
      dist_nxt = DIST_MIN;
    end else begin
      dist_nxt = sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= ch_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dist_r <= dist_nxt;
    end
  end

  assign out_dist.valid    = out_vld_r;
  assign out_dist.distance = out_dist_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ch_vld[0]) && $stable(ch_vld[RW]))
    else $error("root chain moved while stalled");

  a_out_follows_chain: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r == $past(ch_vld[RW]))
    else $error("output valid does not follow last cell");

  a_shape_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_paddr[2] == REG_SHAPE) |=>
      shape_r == shape_t'($past(cfg_pwdata[SHP_W-1:0])))
    else $error("shape register write lost");

  a_radius_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_paddr[2] == REG_RADIUS) |=>
      radius_r == $past(cfg_pwdata[RAD_W-1:0]) && $stable(shape_r))
    else $error("radius register write wrong");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 2d distance field primitive evaluator
// ----------------------------------------------------------------------------
// Query points go in through a valid/ready channel and are checked one for
// one against a behavioral predictor of all four primitives. Shape and radius
// are set over the apb-style port while the pipeline is empty, then read back.
// A short directed pass covers region corners, ties and extremes, and random
// phases follow with bursty input and a stalling result side. One long
// result-side hold-off lets the pipeline fill and push back on the input.
// ----------------------------------------------------------------------------

module tb_top;
  import sdf2d_pkg::*;

  localparam int ONE         = 1 << FRAC_BITS_DEF;
  // 4 front/back stages plus one root cell per length bit, default fraction
  localparam int LAT_CYCLES  = 4 + 15 + 3;
  localparam int MAX_CYCLES  = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 120;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // input side, driven at the rising edge
  logic                   in_valid = 1'b0;
  logic signed [PT_W-1:0] in_x     = '0;
  logic signed [PT_W-1:0] in_y     = '0;
  // result side ready
  logic                   rcv_ready = 1'b0;

  // configuration port
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  sdf2d_pt_if   pt_if ();
  sdf2d_dist_if dist_if ();

  assign pt_if.valid   = in_valid;
  assign pt_if.point_x = in_x;
  assign pt_if.point_y = in_y;
  assign dist_if.ready = rcv_ready;

  sdf2d_primitive_eval dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pt       (pt_if),
    .out_dist    (dist_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor copy of the registers, starts at the reset values
  shape_t           cur_shape  = shape_t'(SHAPE_RST);
  logic [RAD_W-1:0] cur_radius = RADIUS_RST;

  // distances still owed by the block, oldest first
  logic signed [DIST_W-1:0] expected_dist[$];
  logic signed [DIST_W-1:0] want_dist;

  int cyc       = 0;
  int errors    = 0;
  int n_points  = 0;
  int n_checked = 0;
  int n_writes  = 0;

  // sender burst control
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  // long hold-off requests from the test sequence, served by the receiver
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // floor of the euclidean length, exact on integers
  function automatic longint root_len(input longint a, input longint b);
    longint sq;
    longint r;
    sq = a * a + b * b;
    r  = longint'($floor($sqrt(real'(sq))));
    while (r * r > sq) r--;
    while ((r + 1) * (r + 1) <= sq) r++;
    return r;
  endfunction

  // box of half-size one, true absolute value per axis
  function automatic longint box_dist(input longint x, input longint y);
    longint dx;
    longint dy;
    longint inner;
    dx    = (x < 0 ? -x : x) - ONE;
    dy    = (y < 0 ? -y : y) - ONE;
    inner = (dx > dy) ? dx : dy;
    if (inner > 0) inner = 0;
    return inner + root_len(dx > 0 ? dx : 0, dy > 0 ? dy : 0);
  endfunction

  // right triangle (0,0)-(1,0)-(0,1); region tests in fixed priority order
  function automatic longint tri_dist(input longint x, input longint y);
    longint ex;
    longint ey;
    longint s;
    longint diag;
    longint d;
    ex   = x - ONE;
    ey   = y - ONE;
    s    = x + y - ONE;
    // diagonal edge distance, s/sqrt(2) rounded half up
    diag = (s * INV_SQRT2_Q16 + 32768) >>> 16;
    if (x < 0 && y < 0) return root_len(x, y);
    if (ex > 0 && y <= ex) return root_len(ex, y);
    if (ey > 0 && ey >= x) return root_len(x, ey);
    if (y < 0) return -y;
    if (x < 0) return -x;
    if (s > 0) return diag;
    d = -x;
    if (-y > d) d = -y;
    if (diag > d) d = diag;
    return d;
  endfunction

  // segment (0,0)-(1,0): signed y over the closed span, end distance beyond
  function automatic longint seg_dist(input longint x, input longint y);
    if (x >= 0 && x <= ONE) return y;
    if (x < 0) return root_len(x, y);
    return root_len(x - ONE, y);
  endfunction

  function automatic logic signed [DIST_W-1:0] predict_distance(
      input logic signed [PT_W-1:0] px, input logic signed [PT_W-1:0] py);
    longint x;
    longint y;
    longint d;
    x = px;
    y = py;
    case (cur_shape)
      SHAPE_CIRCLE:   d = root_len(x, y) - longint'(cur_radius);
      SHAPE_BOX:      d = box_dist(x, y);
      SHAPE_TRIANGLE: d = tri_dist(x, y);
      default:        d = seg_dist(x, y);
    endcase
    // clamp to the output word
    if (d > longint'(DIST_MAX)) d = longint'(DIST_MAX);
    if (d < longint'(DIST_MIN)) d = longint'(DIST_MIN);
    return d[DIST_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // cycle counter and run limit
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d items outstanding", cyc, expected_dist.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern picked from the cycle counter, plus long holds
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rcv_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      // start a long hold-off, counted here
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES - 1;
      rcv_ready <= 1'b0;
    end else begin
      case ((cyc >> 8) & 3)
        0:       rcv_ready <= 1'b1;
        1:       rcv_ready <= 1'($urandom_range(0, 1));
        2:       rcv_ready <= ($urandom_range(0, 3) != 0);
        default: rcv_ready <= ((cyc % 8) < 3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result checker: every accepted item against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && dist_if.valid && dist_if.ready) begin
      n_checked++;
      if (expected_dist.size() == 0) begin
        errors++;
        $error("distance: expected none, actual %0d", dist_if.distance);
      end else begin
        want_dist = expected_dist.pop_front();
        if (dist_if.distance !== want_dist) begin
          errors++;
          $error("distance: expected %0d, actual %0d", want_dist, dist_if.distance);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // shared stimulus tasks
  // --------------------------------------------------------------------------

  // offer one point, with a random gap at the start of each burst
  task automatic send_point(input int px, input int py);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_x     <= px[PT_W-1:0];
    in_y     <= py[PT_W-1:0];
    do @(posedge clk); while (!pt_if.ready);
    // accepted at this edge
    expected_dist.push_back(predict_distance(in_x, in_y));
    n_points++;
  endtask

  // stop offering and let every owed item come out
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_dist.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_read(input logic idx, input logic [CFG_DW-1:0] want,
                          input string name);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      errors++;
      $error("%s: expected %0d, actual %0d", name, want, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register, update the predictor copy, read it back
  task automatic cfg_write(input logic idx, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    n_writes++;
    // only the low bits of the register width are kept
    if (idx == REG_SHAPE) begin
      cur_shape = shape_t'(data[SHP_W-1:0]);
      cfg_read(idx, CFG_DW'(cur_shape), "shape_select");
    end else begin
      cur_radius = data[RAD_W-1:0];
      cfg_read(idx, CFG_DW'(cur_radius), "circle_radius");
    end
  endtask

  // upper bits get random junk to exercise the truncation
  task automatic set_shape(input shape_t s);
    settle();
    cfg_write(REG_SHAPE, ($urandom() & ~CFG_DW'(3)) | CFG_DW'(s));
  endtask

  task automatic set_radius(input int r);
    settle();
    cfg_write(REG_RADIUS, ($urandom() & ~CFG_DW'(32'h7fff)) | CFG_DW'(r[RAD_W-1:0]));
  endtask

  // coordinate mix: full range, near the primitives, near the unit lines,
  // and the extremes
  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0, 1:    return int'($urandom_range(0, 65535)) - 32768;
      2, 3:    return int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
      4:       return int'($urandom_range(0, 32)) - 16 + ONE * (int'($urandom_range(0, 2)) - 1);
      default: return $urandom_range(0, 1) ? 32767 : -32768;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // test tasks
  // --------------------------------------------------------------------------

  task automatic test_reset_values();
    cfg_read(REG_SHAPE, CFG_DW'(SHAPE_RST), "shape_select");
    cfg_read(REG_RADIUS, CFG_DW'(RADIUS_RST), "circle_radius");
  endtask

  // triangle is the reset shape, so no write before these
  task automatic test_triangle_regions();
    send_point(-1, -1);                  // origin corner
    send_point(2 * ONE, ONE);            // corner (1,0), tie on y = x-1
    send_point(ONE + 100, 0);            // corner (1,0)
    send_point(0, 2 * ONE);              // corner (0,1)
    send_point(100, ONE + 904);          // corner (0,1)
    send_point(2000, -50);               // bottom edge
    send_point(-50, 2000);               // left edge
    send_point(3000, 3000);              // beyond the diagonal
    send_point(ONE / 2, ONE / 2);        // on the diagonal
    send_point(1000, 1000);              // inside
    send_point(32767, -32768);           // far extreme
  endtask

  task automatic test_circle_radius();
    set_shape(SHAPE_CIRCLE);
    set_radius(ONE);
    send_point(0, 0);
    send_point(ONE, 0);
    send_point(-32768, -32768);
    set_radius(32767);                   // largest radius
    send_point(0, 0);
    send_point(-32768, 0);
    set_radius(0);                       // zero radius
    send_point(3, 4);
  endtask

  task automatic test_box();
    set_shape(SHAPE_BOX);
    send_point(0, 0);
    send_point(-32768, -32768);          // abs of the most negative value
    send_point(ONE, -ONE);               // on a corner
    send_point(-6000, 100);
    send_point(32767, 0);
  endtask

  task automatic test_segment();
    set_shape(SHAPE_SEGMENT);
    send_point(0, -32768);               // start of span
    send_point(ONE, 32767);              // end of span
    send_point(-1, 5);                   // just before the span
    send_point(ONE + 1, -5);             // just past the span
  endtask

  task automatic test_random_phases();
    int x;
    int y;
    for (int ph = 0; ph < 8; ph++) begin
      set_shape(ph < 4 ? shape_t'(ph) : shape_t'($urandom_range(0, 3)));
      set_radius($urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 4 * ONE));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        x = pick_coord();
        case ($urandom_range(0, 7))
          0:       y = x - ONE + int'($urandom_range(0, 8)) - 4;   // near y = x-1
          1:       y = ONE - x + int'($urandom_range(0, 8)) - 4;   // near the diagonal
          2:       y = x + ONE + int'($urandom_range(0, 8)) - 4;   // near y-1 = x
          default: y = pick_coord();
        endcase
        send_point(x, y);
      end
    end
  endtask

  // long result-side hold while the input is offered with no gaps
  task automatic test_output_stall();
    set_shape(shape_t'($urandom_range(0, 3)));
    gaps_on    = 1'b0;
    burst_left = 0;
    hold_reqs++;
    for (int i = 0; i < 80; i++) send_point(pick_coord(), pick_coord());
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_triangle_regions();
    test_circle_radius();
    test_box();
    test_segment();
    test_random_phases();
    test_output_stall();

    settle();
    repeat (LAT_CYCLES + 8) @(posedge clk);

    $display("covered %0d points over circle, box, triangle and segment, %0d register writes",
             n_points, n_writes);
    $display("%0d distance items checked, %0d errors", n_checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sdf2d_pkg.sv
rtl/sdf2d_if.sv
rtl/sdf2d_front.sv
rtl/sdf2d_sqrt_cell.sv
rtl/sdf2d_primitive_eval.sv
tb/sv/tb_top.sv
